// ----- rtl/sc2a_pkg.sv -----
package sc2a_pkg;

    localparam int unsigned BREAK_BIT = 7;

    localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
    localparam logic [6:0] KEY_SHIFT_R = 7'h36;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [6:0] CASE_OFFSET = 7'd32;

    typedef struct packed {
        logic shift;
        logic caps;
    } flags_t;

    // unshifted character per key, 0 for keys without one
    function automatic logic [6:0] key_ascii(input logic [6:0] key);
        logic [6:0] c;
        begin
            case (key)
                7'h02: c = 7'h31;
                7'h03: c = 7'h32;
                7'h04: c = 7'h33;
                7'h05: c = 7'h34;
                7'h06: c = 7'h35;
                7'h07: c = 7'h36;
                7'h08: c = 7'h37;
                7'h09: c = 7'h38;
                7'h0A: c = 7'h39;
                7'h0B: c = 7'h30;
                7'h0C: c = 7'h2D;
                7'h0D: c = 7'h3D;
                7'h0E: c = 7'h08;
                7'h10: c = 7'h71;
                7'h11: c = 7'h77;
                7'h12: c = 7'h65;
                7'h13: c = 7'h72;
                7'h14: c = 7'h74;
                7'h15: c = 7'h79;
                7'h16: c = 7'h75;
                7'h17: c = 7'h69;
                7'h18: c = 7'h6F;
                7'h19: c = 7'h70;
                7'h1A: c = 7'h5B;
                7'h1B: c = 7'h5D;
                7'h1C: c = 7'h0D;
                7'h1E: c = 7'h61;
                7'h1F: c = 7'h73;
                7'h20: c = 7'h64;
                7'h21: c = 7'h66;
                7'h22: c = 7'h67;
                7'h23: c = 7'h68;
                7'h24: c = 7'h6A;
                7'h25: c = 7'h6B;
                7'h26: c = 7'h6C;
                7'h27: c = 7'h3B;
                7'h28: c = 7'h27;
                7'h29: c = 7'h60;
                7'h2B: c = 7'h5C;
                7'h2C: c = 7'h7A;
                7'h2D: c = 7'h78;
                7'h2E: c = 7'h63;
                7'h2F: c = 7'h76;
                7'h30: c = 7'h62;
                7'h31: c = 7'h6E;
                7'h32: c = 7'h6D;
                7'h33: c = 7'h2C;
                7'h34: c = 7'h2E;
                7'h35: c = 7'h2F;
                7'h37: c = 7'h2A;
                7'h39: c = 7'h20;
                7'h48: c = 7'h38;
                7'h50: c = 7'h32;
                7'h51: c = 7'h33;
                7'h52: c = 7'h30;
                7'h53: c = 7'h2E;
                default: c = 7'h00;
            endcase
            return c;
        end
    endfunction

    // shifted form of digits and punctuation, identity otherwise
    function automatic logic [6:0] shifted_char(input logic [6:0] c);
        logic [6:0] s;
        begin
            case (c)
                7'h30: s = 7'h29;
                7'h31: s = 7'h21;
                7'h32: s = 7'h40;
                7'h33: s = 7'h23;
                7'h34: s = 7'h24;
                7'h35: s = 7'h25;
                7'h36: s = 7'h5E;
                7'h37: s = 7'h26;
                7'h38: s = 7'h2A;
                7'h39: s = 7'h28;
                7'h2C: s = 7'h3C;
                7'h2E: s = 7'h3E;
                7'h2F: s = 7'h3F;
                7'h3B: s = 7'h3A;
                7'h27: s = 7'h22;
                7'h5B: s = 7'h7B;
                7'h5D: s = 7'h7D;
                7'h60: s = 7'h7E;
                7'h2D: s = 7'h5F;
                7'h5C: s = 7'h7C;
                default: s = c;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- rtl/sc2a_xlate.sv -----
module sc2a_xlate (
    input  logic [7:0]      code,
    input  sc2a_pkg::flags_t flags,
    output sc2a_pkg::flags_t flags_next,
    output logic [6:0]      ascii,
    output logic            led_upd,
    output logic [2:0]      leds
);
    import sc2a_pkg::*;

    logic [6:0] key;
    logic       is_break;
    logic       is_shift;
    logic [6:0] base;
    logic [6:0] cased;

    assign key      = code[6:0];
    assign is_break = code[BREAK_BIT];
    assign is_shift = (key == KEY_SHIFT_L) || (key == KEY_SHIFT_R);
    assign base     = key_ascii(key);

    always_comb
    begin
        if ((flags.shift || flags.caps) && (base inside {[7'h61:7'h7A]}))
            cased = base - CASE_OFFSET;
        else
            cased = base;
    end

    always_comb
    begin
        flags_next = flags;
        ascii      = 7'h00;
        led_upd    = 1'b0;
        leds       = 3'b000;
        if (is_break)
        begin
            if (is_shift)
                flags_next.shift = 1'b0;
            else if (flags.shift && !flags.caps)
                ascii = shifted_char(cased);
            else
                ascii = cased;
        end
        else
        begin
            if (is_shift)
                flags_next.shift = 1'b1;
            else if (key == KEY_CAPS)
            begin
                flags_next.caps = !flags.caps;
                led_upd         = 1'b1;
                leds            = {!flags.caps, 2'b00};
            end
        end
    end

endmodule

// ----- rtl/scancode_set1_to_ascii_unit.sv -----
// Scan code set 1 to ASCII translator.
// Input channel: scan_valid / scan_stall with the raw byte on scan_code.
// Bit 7 marks a break code. A word is taken at an edge with valid high and
// stall low.
// Output channel: char_valid / char_stall carrying ascii_char, led_update and
// led_bits. Every input word yields exactly one output word, in order.
// A taken word is registered in the input stage, passes the lookup and flag
// logic, and lands in the output register when the input stage advances; it
// is offered from then on. Throughput is one word per cycle while char_stall
// stays low; the input stage and the output register form a two-deep pipeline.
// When char_stall is high with a word waiting, the output holds, the input
// stage fills, and scan_stall rises once both stages are occupied.
// Shift and caps flags are updated as a word leaves the input stage.
// Reset clears both stages and the flags (shift released, caps lock off).
module scancode_set1_to_ascii_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    output logic       scan_stall,
    input  logic [7:0] scan_code,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] ascii_char,
    output logic       led_update,
    output logic [2:0] led_bits
);
    import sc2a_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_code_reg;
    logic       out_valid_reg;
    logic [6:0] ascii_reg;
    logic       led_upd_reg;
    logic [2:0] leds_reg;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic [6:0] ascii_next;
    logic       led_upd_next;
    logic [2:0] leds_next;
    logic       s1_adv;
    logic       scan_take;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || !char_stall);
    assign scan_stall = s1_valid_reg && !s1_adv;
    assign scan_take  = scan_valid && !scan_stall;

    sc2a_xlate u_xlate (
        .code       (s1_code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .ascii      (ascii_next),
        .led_upd    (led_upd_next),
        .leds       (leds_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (scan_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (!char_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
            s1_code_reg <= scan_code;
        if (s1_adv)
        begin
            ascii_reg   <= ascii_next;
            led_upd_reg <= led_upd_next;
            leds_reg    <= leds_next;
        end
    end

    assign char_valid = out_valid_reg;
    assign ascii_char = ascii_reg;
    assign led_update = led_upd_reg;
    assign led_bits   = leds_reg;

    a_led_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && led_upd_reg |-> ascii_reg == 7'h00)
        else $error("led word carries a character");

    a_leds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !led_upd_reg |-> leds_reg == 3'b000)
        else $error("led bits set without update");

    a_leds_caps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && led_upd_reg |-> leds_reg[2] == flags_reg.caps)
        else $error("led caps bit differs from caps flag");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_code_reg))
        else $error("input stage lost a blocked word");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(flags_reg))
        else $error("flags changed without a word advancing");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sc2a_pkg::*;

    typedef struct packed {
        logic [6:0] ch;
        logic       upd;
        logic [2:0] leds;
    } char_word_t;

    typedef struct {
        logic [7:0] code;
        bit         drain_first;
    } scan_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       scan_valid = 1'b0;
    logic       scan_stall;
    logic [7:0] scan_code = 8'h00;
    logic       char_valid;
    logic       char_stall = 1'b0;
    logic [6:0] ascii_char;
    logic       led_update;
    logic [2:0] led_bits;

    scan_item_t scan_backlog[$];
    char_word_t char_expected[$];
    char_word_t head;
    logic [6:0] glyph [128];
    string      shifted_digits = ")!@#$%^&*(";
    logic       shift_down = 1'b0;
    logic       caps_lock = 1'b0;
    int         words_sent = 0;
    int         words_total = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         errors = 0;

    scancode_set1_to_ascii_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_code  (scan_code),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .led_update (led_update),
        .led_bits   (led_bits)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void place_row(input int base, input string s);
        for (int i = 0; i < s.len(); i++)
            glyph[base + i] = 7'(s[i]);
    endfunction

    // updates the shift/caps flags and returns the word the block should emit
    function automatic char_word_t translate_scan(input logic [7:0] code);
        char_word_t w;
        logic [6:0] key;
        logic [6:0] c;
        begin
            w = '0;
            key = code[6:0];
            if (code[BREAK_BIT])
            begin
                if (key == KEY_SHIFT_L || key == KEY_SHIFT_R)
                    shift_down = 1'b0;
                else
                begin
                    c = glyph[key];
                    if ((shift_down || caps_lock) && c >= "a" && c <= "z")
                        c = c - CASE_OFFSET;
                    if (shift_down && !caps_lock)
                    begin
                        if (c >= "0" && c <= "9")
                            c = 7'(shifted_digits[c - 7'h30]);
                        else
                        begin
                            case (c)
                                7'h2C: c = 7'h3C;
                                7'h2E: c = 7'h3E;
                                7'h2F: c = 7'h3F;
                                7'h3B: c = 7'h3A;
                                7'h27: c = 7'h22;
                                7'h5B: c = 7'h7B;
                                7'h5D: c = 7'h7D;
                                7'h60: c = 7'h7E;
                                7'h2D: c = 7'h5F;
                                7'h5C: c = 7'h7C;
                                default: c = c;
                            endcase
                        end
                    end
                    w.ch = c;
                end
            end
            else if (key == KEY_SHIFT_L || key == KEY_SHIFT_R)
                shift_down = 1'b1;
            else if (key == KEY_CAPS)
            begin
                caps_lock = !caps_lock;
                w.upd = 1'b1;
                w.leds = {caps_lock, 2'b00};
            end
            return w;
        end
    endfunction

    task automatic add_code(input logic [7:0] code, input bit drain_first = 1'b0);
        scan_item_t it;
        begin
            it.code = code;
            it.drain_first = drain_first;
            scan_backlog.push_back(it);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid <= 1'b0;
            scan_code <= 8'h00;
        end
        else
        begin
            if (scan_valid && !scan_stall)
            begin
                char_expected.push_back(translate_scan(scan_code));
                words_sent++;
            end
            if (!scan_valid || !scan_stall)
            begin
                if (scan_backlog.size() > 0
                    && !(scan_backlog[0].drain_first && char_expected.size() > 0)
                    && $urandom_range(99) >= idle_pct)
                begin
                    scan_code <= scan_backlog[0].code;
                    scan_valid <= 1'b1;
                    void'(scan_backlog.pop_front());
                end
                else
                    scan_valid <= 1'b0;
            end
            case ((words_sent / 100) % 4)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 66; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 66; end
                default: begin idle_pct <= 29; stall_pct <= 29; end
            endcase
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_stall <= 1'b0;
        else
        begin
            if (char_valid && !char_stall)
            begin
                if (char_expected.size() == 0)
                begin
                    $error("unexpected word: ascii_char %h led_update %b led_bits %h",
                           ascii_char, led_update, led_bits);
                    errors++;
                end
                else
                begin
                    head = char_expected.pop_front();
                    if (ascii_char !== head.ch)
                    begin
                        $error("ascii_char: expected %h, got %h", head.ch, ascii_char);
                        errors++;
                    end
                    if (led_update !== head.upd)
                    begin
                        $error("led_update: expected %b, got %b", head.upd, led_update);
                        errors++;
                    end
                    if (led_bits !== head.leds)
                    begin
                        $error("led_bits: expected %h, got %h", head.leds, led_bits);
                        errors++;
                    end
                end
            end
            char_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        int roll;
        int next_drain;
        int n;
        logic [6:0] k;
        logic [6:0] sh;

        for (int i = 0; i < 128; i++)
            glyph[i] = 7'h00;
        place_row(8'h02, "1234567890-=");
        place_row(8'h10, "qwertyuiop[]");
        place_row(8'h1E, "asdfghjkl;'");
        place_row(8'h2C, "zxcvbnm,./");
        glyph[8'h0E] = 7'h08;
        glyph[8'h1C] = 7'h0D;
        glyph[8'h29] = 7'h60;
        glyph[8'h2B] = 7'h5C;
        glyph[8'h37] = 7'h2A;
        glyph[8'h39] = 7'h20;
        glyph[8'h48] = 7'h38;
        glyph[8'h50] = 7'h32;
        glyph[8'h51] = 7'h33;
        glyph[8'h52] = 7'h30;
        glyph[8'h53] = 7'h2E;

        // directed: extremes, shift, caps, caps+shift, non-ASCII and unmapped keys
        add_code(8'h00);
        add_code(8'hFF);
        add_code(8'h80);
        add_code(8'h7F);
        add_code(8'h9E);
        add_code({1'b0, KEY_SHIFT_L});
        add_code(8'h9E);
        add_code(8'h82);
        add_code(8'h84);
        add_code(8'h85);
        add_code(8'hB5);
        add_code({1'b0, KEY_CAPS}, 1'b1);
        add_code({1'b1, KEY_CAPS});
        add_code(8'h9E);
        add_code(8'h82);
        add_code({1'b1, KEY_SHIFT_L});
        add_code(8'h9E);
        add_code(8'h82);
        add_code({1'b0, KEY_CAPS});
        add_code(8'h81);
        add_code(8'h8F);
        add_code(8'hC8);
        add_code(8'hCA);
        add_code(8'hD9);
        add_code({1'b0, KEY_SHIFT_R});
        add_code(8'hA9);
        add_code({1'b1, KEY_SHIFT_R});

        next_drain = 300;
        while (scan_backlog.size() < 1175)
        begin
            roll = $urandom_range(99);
            if (scan_backlog.size() >= next_drain)
            begin
                add_code(8'h00, 1'b1);
                next_drain += 300;
            end
            if (roll < 10)
                add_code(8'($urandom_range(255)));
            else if (roll < 18)
            begin
                add_code({1'b0, KEY_CAPS});
                add_code({1'b1, KEY_CAPS});
            end
            else
            begin
                n = 1;
                sh = $urandom_range(1) ? KEY_SHIFT_L : KEY_SHIFT_R;
                if (roll < 45)
                begin
                    n = $urandom_range(1, 3);
                    add_code({1'b0, sh});
                end
                for (int j = 0; j < n; j++)
                begin
                    if ($urandom_range(9) == 0)
                        k = 7'($urandom_range(127));
                    else
                        k = 7'($urandom_range(8'h01, 8'h58));
                    add_code({1'b0, k});
                    add_code({1'b1, k});
                end
                if (roll < 45)
                    add_code({1'b1, ($urandom_range(3) == 0) ? KEY_SHIFT_L ^ KEY_SHIFT_R ^ sh : sh});
            end
        end
        words_total = scan_backlog.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (words_sent == words_total);
        wait (char_expected.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sc2a_pkg.sv
rtl/sc2a_xlate.sv
rtl/scancode_set1_to_ascii_unit.sv
tb/tb_top.sv
